>>> src/sact_pkg.sv
// Package for the set-associative cache tag simulator: constants, register
// indexes and the controller/datapath command and status structs.
`default_nettype none
package sact_pkg;
   localparam int LINES_DEF     = 256;
   localparam int ADDR_BITS_DEF = 48;
   localparam int CFG_W         = 4;
   localparam int CNT_W         = 32;

   // Configuration register indexes
   localparam logic [1:0] REG_OFFSET = 2'd0;
   localparam logic [1:0] REG_SET    = 2'd1;
   localparam logic [1:0] REG_WAY    = 2'd2;
   localparam logic [1:0] REG_POLICY = 2'd3;

   // Controller to datapath
   typedef struct packed {
      logic start;     // latch item, set up geometry
      logic scan;      // read entry at way counter, compare
      logic step;      // advance way counter
      logic commit;    // write victim / update counts
      logic rank;      // rank update pass step
      logic finish;    // load result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_way;
      logic hit;
      logic need_rank;
   } sts_type;
endpackage
`default_nettype wire

>>> src/set_assoc_cache_tag_sim.sv
// Set-associative cache tag simulator (FIFO or LRU). One access at a time:
// an item takes a read and a compare step per way scanned until a hit (or
// all ways), a commit step, and when ranks move (LRU hit, or replacement of
// a full set) a rank read and a rank update step per way, then a step that
// posts the result (it waits while a held result is stalled) and an idle
// step to accept the next item; the default has 4 ways. Configure only while idle.
// The steps follow the single-port tag/rank memory walk. Counts saturate at 2^32-1.
`default_nettype none
module set_assoc_cache_tag_sim #(
   parameter int LINES     = sact_pkg::LINES_DEF,
   parameter int ADDR_BITS = sact_pkg::ADDR_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [1:0]           csr_index,
   input  wire logic [3:0]           csr_data,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [ADDR_BITS-1:0] req_address,
   input  wire logic                 req_mode,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_hit,
   output logic                      rsp_memory_read,
   output logic                      rsp_memory_write,
   output logic [31:0]               rsp_read_total,
   output logic [31:0]               rsp_write_total,
   output logic [31:0]               rsp_hit_total,
   output logic [31:0]               rsp_miss_total
);
   sact_pkg::cmd_type cmd;
   sact_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   sact_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .sts
   );

   sact_dp #(.LINES(LINES), .ADDR_BITS(ADDR_BITS)) u_dp (
      .clock, .reset, .csr_valid, .csr_index, .csr_data,
      .req_address, .req_mode, .cmd, .sts,
      .rsp_hit, .rsp_memory_read, .rsp_memory_write,
      .rsp_read_total, .rsp_write_total, .rsp_hit_total, .rsp_miss_total
   );
endmodule
`default_nettype wire

>>> src/sact_ctrl.sv
// Controller state machine for the cache tag simulator.
// Depends on sact_pkg for cmd_type and sts_type.
`default_nettype none
module sact_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sact_pkg::cmd_type     cmd,
   input  wire sact_pkg::sts_type sts
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_CMP, ST_COMMIT, ST_RANK_RD, ST_RANK, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   wire accept = req_valid && !req_stall;

   // Busy while an item is in flight; results wait in a register
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.start = 1'b1;
               state_in  = ST_READ;
            end
         end
         ST_READ: state_in = ST_CMP;
         ST_CMP: begin
            cmd.scan = 1'b1;
            if (sts.hit || sts.last_way) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = sts.need_rank ? ST_RANK_RD : ST_DONE;
         end
         ST_RANK_RD: state_in = ST_RANK;
         ST_RANK: begin
            cmd.rank = 1'b1;
            if (sts.last_way) begin
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_RANK_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result is never overwritten while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !cmd.finish) else $error("result overwritten");
   // Only one item in flight
   a_one: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> $past(state_ff) != ST_READ) else $error("double start");
   a_fin: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid) else $error("finish without valid");
endmodule
`default_nettype wire

>>> src/sact_dp.sv
// Datapath for the cache tag simulator: config registers, tag/valid/rank
// memories, way scan, victim selection, counters. Depends on sact_pkg.
`default_nettype none
module sact_dp #(
   parameter int LINES     = sact_pkg::LINES_DEF,
   parameter int ADDR_BITS = sact_pkg::ADDR_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire logic [1:0]            csr_index,
   input  wire logic [3:0]            csr_data,
   input  wire logic [ADDR_BITS-1:0]  req_address,
   input  wire logic                  req_mode,
   input  wire sact_pkg::cmd_type     cmd,
   output sact_pkg::sts_type          sts,
   output logic                       rsp_hit,
   output logic                       rsp_memory_read,
   output logic                       rsp_memory_write,
   output logic [31:0]                rsp_read_total,
   output logic [31:0]                rsp_write_total,
   output logic [31:0]                rsp_hit_total,
   output logic [31:0]                rsp_miss_total
);
   localparam int LG  = $clog2(LINES + 1) - 1;   // floor(log2(LINES))
   localparam int IW  = (LG < 1) ? 1 : LG;       // line index width
   localparam int WCW = IW + 1;                  // way counter, holds ways
   localparam int RW  = 8;                       // rank width

   // Config registers
   logic [3:0] off_ff, sb_cfg_ff, wb_cfg_ff;
   logic       pol_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= 4'd4; sb_cfg_ff <= 4'd4; wb_cfg_ff <= 4'd2; pol_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            sact_pkg::REG_OFFSET: off_ff    <= csr_data;
            sact_pkg::REG_SET:    sb_cfg_ff <= csr_data;
            sact_pkg::REG_WAY:    wb_cfg_ff <= csr_data;
            sact_pkg::REG_POLICY: pol_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Clamped geometry
   logic [4:0] sb_c, wb_c;
   always_comb begin
      sb_c = (5'(sb_cfg_ff) > 5'(LG)) ? 5'(LG) : 5'(sb_cfg_ff);
      wb_c = (5'(wb_cfg_ff) > 5'(LG) - sb_c) ? 5'(LG) - sb_c : 5'(wb_cfg_ff);
   end

   // Item registers
   logic [ADDR_BITS-1:0] tag_ff;
   logic [IW-1:0]        base_ff;
   logic [WCW-1:0]       ways_ff, w_ff;
   logic                 wr_ff, hit_ff, pol_i_ff;
   logic [WCW-1:0]       free_ff, vict_ff, me_ff;
   logic                 free_found_ff, vict_found_ff;
   logic [RW-1:0]        valid_cnt_ff, old_ff;
   logic                 ins_ff;      // rank pass is the update pass

   // Memories
   logic [ADDR_BITS-1:0] tag_mem [LINES];
   logic [RW-1:0]        rank_mem [LINES];
   logic [LINES-1:0]     valid_ff;

   logic [IW-1:0]        li;
   assign li = IW'(base_ff + IW'(w_ff));

   logic [ADDR_BITS-1:0] rd_tag_ff;
   logic [RW-1:0]        rd_rank_ff;
   logic                 rd_valid_ff;
   logic [IW-1:0]        rd_li_ff;

   wire last = (w_ff == ways_ff - 1'b1);
   wire match = rd_valid_ff && (rd_tag_ff == tag_ff) && !ins_ff;
   assign sts.hit       = cmd.scan ? match : 1'b0;
   assign sts.last_way  = last;
   // Victim / newest index at commit
   logic [WCW-1:0] tgt;
   always_comb begin
      if (hit_ff)              tgt = me_ff;
      else if (free_found_ff)  tgt = free_ff;
      else if (vict_found_ff)  tgt = vict_ff;
      else                     tgt = '0;
   end
   assign sts.need_rank = hit_ff ? pol_i_ff : !free_found_ff;
   logic [IW-1:0] tli;
   assign tli = IW'(base_ff + IW'(tgt));

   logic [31:0] rc_ff, wc_ff, hc_ff, mc_ff;
   function automatic logic [31:0] sat(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // Memory read at way index
   always_ff @(posedge clock) begin
      rd_tag_ff  <= tag_mem[li];
      rd_rank_ff <= rank_mem[li];
      rd_li_ff   <= li;
   end
   always_ff @(posedge clock) begin
      if (reset) rd_valid_ff <= 1'b0;
      else       rd_valid_ff <= valid_ff[li];
   end

   logic [ADDR_BITS-1:0] sh;
   assign sh = req_address >> off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rc_ff <= '0; wc_ff <= '0; hc_ff <= '0; mc_ff <= '0;
         w_ff <= '0;
      end else begin
         if (cmd.start) begin
            tag_ff   <= sh >> sb_c;
            base_ff  <= IW'((sh & ((ADDR_BITS'(1) << sb_c) - 1'b1)) << wb_c);
            ways_ff  <= WCW'(1) << wb_c;
            wr_ff    <= req_mode;
            pol_i_ff <= pol_ff;
            w_ff     <= '0;
            hit_ff   <= 1'b0;
            free_found_ff <= 1'b0;
            vict_found_ff <= 1'b0;
            valid_cnt_ff  <= '0;
            ins_ff   <= 1'b0;
         end
         if (cmd.scan) begin
            if (match) begin
               hit_ff <= 1'b1;
               me_ff  <= w_ff;
            end
            // Old rank of the way that becomes newest: hit way, first rank 0 way,
            // else way 0
            if (match || (rd_valid_ff && rd_rank_ff == '0 && !vict_found_ff) ||
                w_ff == '0)
               old_ff <= rd_rank_ff;
            if (rd_valid_ff) begin
               valid_cnt_ff <= valid_cnt_ff + 1'b1;
               if (rd_rank_ff == '0 && !vict_found_ff) begin
                  vict_found_ff <= 1'b1;
                  vict_ff       <= w_ff;
               end
            end else if (!free_found_ff) begin
               free_found_ff <= 1'b1;
               free_ff       <= w_ff;
            end
         end
         if (cmd.step) w_ff <= w_ff + 1'b1;
         if (cmd.commit) begin
            w_ff   <= '0;
            ins_ff <= 1'b1;
            valid_cnt_ff <= '0;
            if (!hit_ff) begin
               tag_mem[tli]  <= tag_ff;
               valid_ff[tli] <= 1'b1;
               if (free_found_ff) rank_mem[tli] <= valid_cnt_ff;
               rc_ff <= sat(rc_ff);
               mc_ff <= sat(mc_ff);
            end else begin
               hc_ff <= sat(hc_ff);
            end
            if (wr_ff) wc_ff <= sat(wc_ff);
            me_ff  <= tgt;
         end
         // Rank pass: decrement newer ranks, then set target to newest
         if (cmd.rank) begin
            if (rd_valid_ff) begin
               if (w_ff != me_ff && rd_rank_ff > old_ff)
                  rank_mem[rd_li_ff] <= rd_rank_ff - 1'b1;
               valid_cnt_ff <= valid_cnt_ff + 1'b1;
            end
            if (last)
               rank_mem[IW'(base_ff + IW'(me_ff))] <=
                  valid_cnt_ff + RW'(rd_valid_ff) - 1'b1;
         end
         if (cmd.finish) begin
            rsp_hit          <= hit_ff;
            rsp_memory_read  <= !hit_ff;
            rsp_memory_write <= wr_ff;
            rsp_read_total   <= rc_ff;
            rsp_write_total  <= wc_ff;
            rsp_hit_total    <= hc_ff;
            rsp_miss_total   <= mc_ff;
         end
      end
   end

   a_sum: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_memory_read != rsp_hit) else $error("hit/read mismatch");
   a_way: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> w_ff < ways_ff) else $error("way out of range");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !hit_ff && mc_ff != 32'hFFFF_FFFF |=> mc_ff == $past(mc_ff) + 1)
      else $error("miss count");
endmodule
`default_nettype wire
